@@ src/saturating_audio_mix_into_ring_top_macros.svh @@
// ----------------------------------------------------------------------------
// Saturating audio mix into ring - assertion macros
// Shared shorthand for the concurrent checks of the mixer, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SATURATING_AUDIO_MIX_INTO_RING_TOP_MACROS_SVH
`define SATURATING_AUDIO_MIX_INTO_RING_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAMR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("samr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SAMR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("samr: next-cycle check failed");

`endif

@@ src/samr_pkg.sv @@
// ----------------------------------------------------------------------------
// Saturating audio mix into ring - package
// Sizes, register codes, transfer structures and the arithmetic helpers that
// the mixer modules share.
// ----------------------------------------------------------------------------
`default_nettype none

package samr_pkg;

    localparam int RING_DEPTH  = 4096;
    localparam int ADDR_W      = $clog2(RING_DEPTH);
    localparam int SIZE_W      = $clog2(RING_DEPTH + 1);

    localparam int SAMPLE_W    = 32;
    localparam int START_W     = 12;
    localparam int OFFSET_W    = 13;
    localparam int COUNT_W     = 13;
    localparam int ADDR_OUT_W  = 12;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 13;
    localparam int FMT_W       = 2;
    localparam int RSIZE_W     = 13;
    // Width of sink_start + start_offset, which is fixed by the field widths.
    localparam int SUM_W       = 14;

    typedef logic [CFG_INDEX_W-1:0] reg_index_t;
    localparam reg_index_t REG_FORMAT    = 1'd0;
    localparam reg_index_t REG_RING_SIZE = 1'd1;

    typedef logic [FMT_W-1:0] fmt_t;
    localparam fmt_t FMT_16 = 2'd0;
    localparam fmt_t FMT_24 = 2'd1;
    localparam fmt_t FMT_32 = 2'd2;

    localparam logic [RSIZE_W-1:0] RING_SIZE_RESET = 13'd4096;

    // One input transaction as it travels through the modulo pipeline.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                first;
        logic [COUNT_W-1:0]  mix_init;
        logic                last;
    } item_t;

    // One resolved ring access, from the address stage to the mix stage.
    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic                mixed;
        logic                last;
        logic [SAMPLE_W-1:0] sample;
    } wr_req_t;

    // Status of the address sequencer.
    typedef struct packed {
        logic clearing;
        logic reducing;
    } seq_stat_t;

    // Ring size in use: zero counts as one, anything above the depth is clipped.
    function automatic logic [SIZE_W-1:0] eff_size(logic [RSIZE_W-1:0] v);
        if (v == '0)
            return SIZE_W'(1);
        if (int'(v) > RING_DEPTH)
            return SIZE_W'(RING_DEPTH);
        return SIZE_W'(v);
    endfunction

    // One step of a restoring remainder: shift in a bit, subtract if it fits.
    function automatic logic [SIZE_W-1:0] mod_step(logic [SIZE_W-1:0] rem, logic b,
                                                   logic [SIZE_W-1:0] size);
        logic [SIZE_W:0] t;
        t = {rem, b};
        if (t >= {1'b0, size})
            t = t - {1'b0, size};
        return t[SIZE_W-1:0];
    endfunction

    // Saturating sum of two samples at the width chosen by the format.
    function automatic logic [SAMPLE_W-1:0] sat_mix(fmt_t fmt, logic [SAMPLE_W-1:0] a,
                                                    logic [SAMPLE_W-1:0] b);
        logic signed [SAMPLE_W:0] ea;
        logic signed [SAMPLE_W:0] eb;
        logic signed [SAMPLE_W:0] s;
        logic signed [SAMPLE_W:0] hi;
        logic signed [SAMPLE_W:0] lo;
        case (fmt)
            FMT_16:
            begin
                ea = (SAMPLE_W+1)'(signed'(a[15:0]));
                eb = (SAMPLE_W+1)'(signed'(b[15:0]));
                hi = (SAMPLE_W+1)'(32'sd32767);
                lo = (SAMPLE_W+1)'(-32'sd32768);
            end
            FMT_24:
            begin
                ea = (SAMPLE_W+1)'(signed'(a[23:0]));
                eb = (SAMPLE_W+1)'(signed'(b[23:0]));
                hi = (SAMPLE_W+1)'(32'sd8388607);
                lo = (SAMPLE_W+1)'(-32'sd8388608);
            end
            default:
            begin
                ea = (SAMPLE_W+1)'(signed'(a));
                eb = (SAMPLE_W+1)'(signed'(b));
                hi = (SAMPLE_W+1)'(32'sh7FFFFFFF);
                lo = -(SAMPLE_W+1)'(33'sh080000000);
            end
        endcase
        s = ea + eb;
        if (s > hi)
            s = hi;
        else if (s < lo)
            s = lo;
        return s[SAMPLE_W-1:0];
    endfunction

    // Value stored when a sample is copied rather than mixed.
    function automatic logic [SAMPLE_W-1:0] copy_val(fmt_t fmt, logic [SAMPLE_W-1:0] a);
        if (fmt == FMT_16)
            return {{(SAMPLE_W-16){a[15]}}, a[15:0]};
        return a;
    endfunction

endpackage

`default_nettype wire

@@ src/samr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. A read of the address being
// written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module samr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ src/samr_modpipe.sv @@
// ----------------------------------------------------------------------------
// Saturating audio mix into ring - modulo pipeline
// Reduces sink_start + start_offset modulo the ring size, one dividend bit
// per stage, while every transaction travels through in order.
// ----------------------------------------------------------------------------
`default_nettype none

module samr_modpipe
    import samr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              load,
    input  wire item_t             load_item,
    input  wire logic [SUM_W-1:0]  load_sum,
    input  wire logic [SIZE_W-1:0] ring_size,
    output logic                   d_valid,
    output item_t                  d_item,
    output logic [ADDR_W-1:0]      d_rem
);

    logic              v_reg   [SUM_W];
    item_t             item_reg[SUM_W];
    logic [SIZE_W-1:0] rem_reg [SUM_W];
    logic [SUM_W-1:0]  dvd_reg [SUM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SUM_W; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= load;
            for (int k = 1; k < SUM_W; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg[0] <= load_item;
            rem_reg[0]  <= mod_step('0, load_sum[SUM_W-1], ring_size);
            dvd_reg[0]  <= load_sum << 1;
            for (int k = 1; k < SUM_W; k++)
            begin
                item_reg[k] <= item_reg[k-1];
                rem_reg[k]  <= mod_step(rem_reg[k-1], dvd_reg[k-1][SUM_W-1], ring_size);
                dvd_reg[k]  <= dvd_reg[k-1] << 1;
            end
        end
    end

    assign d_valid = v_reg[SUM_W-1];
    assign d_item  = item_reg[SUM_W-1];
    // The remainder is below the ring size, so it fits a ring address.
    assign d_rem   = ADDR_W'(rem_reg[SUM_W-1]);

endmodule

`default_nettype wire

@@ src/samr_seq.sv @@
// ----------------------------------------------------------------------------
// Saturating audio mix into ring - address sequencer
// Resolves the ring position and mix decision of each transaction, keeps the
// write index and remaining mix count, runs the clearing pass after reset and
// re-reduces the write index after the ring size changes.
// ----------------------------------------------------------------------------
`default_nettype none

module samr_seq
    import samr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              d_valid,
    input  wire item_t             d_item,
    input  wire logic [ADDR_W-1:0] d_rem,
    input  wire logic [SIZE_W-1:0] ring_size,
    input  wire logic              reduce_start,
    output logic                   issue_valid,
    output wr_req_t                issue_req,
    output logic                   clr_we,
    output logic [ADDR_W-1:0]      clr_addr,
    output seq_stat_t              stat
);

    localparam int RCNT_W = $clog2(ADDR_W + 1);

    logic [ADDR_W-1:0]  idx_reg;
    logic [ADDR_W-1:0]  idx_next;
    logic [COUNT_W-1:0] mix_rem_reg;
    logic [COUNT_W-1:0] mix_rem_next;
    logic               clearing_reg;
    logic [ADDR_W-1:0]  clr_cnt_reg;
    logic               reducing_reg;
    logic [RCNT_W-1:0]  red_cnt_reg;
    logic [SIZE_W-1:0]  red_rem_reg;
    logic [SIZE_W-1:0]  red_step;

    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] rem_cnt;
    logic               mixed;
    logic [SIZE_W-1:0]  addr_inc;

    always_comb
    begin
        addr         = d_item.first ? d_rem : idx_reg;
        rem_cnt      = d_item.first ? d_item.mix_init : mix_rem_reg;
        mixed        = (rem_cnt != '0);
        mix_rem_next = mixed ? rem_cnt - COUNT_W'(1) : rem_cnt;
        addr_inc     = SIZE_W'(addr) + SIZE_W'(1);
        idx_next     = (addr_inc == ring_size) ? '0 : ADDR_W'(addr_inc);
        red_step     = mod_step(red_rem_reg, idx_reg[ADDR_W-1], ring_size);

        issue_valid      = adv && d_valid;
        issue_req.addr   = addr;
        issue_req.mixed  = mixed;
        issue_req.last   = d_item.last;
        issue_req.sample = d_item.sample;
    end

    // Position and mix count; a size change shifts the index through a
    // restoring remainder, one bit per cycle, while no transaction is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            mix_rem_reg  <= '0;
            reducing_reg <= 1'b0;
            red_cnt_reg  <= '0;
            red_rem_reg  <= '0;
        end
        else if (reduce_start)
        begin
            reducing_reg <= 1'b1;
            red_cnt_reg  <= '0;
            red_rem_reg  <= '0;
        end
        else if (reducing_reg)
        begin
            red_rem_reg <= red_step;
            red_cnt_reg <= red_cnt_reg + RCNT_W'(1);
            if (red_cnt_reg == RCNT_W'(ADDR_W - 1))
            begin
                idx_reg      <= ADDR_W'(red_step);
                reducing_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg << 1;
            end
        end
        else if (issue_valid)
        begin
            idx_reg     <= idx_next;
            mix_rem_reg <= mix_rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            if (clr_cnt_reg == ADDR_W'(RING_DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    assign clr_we        = clearing_reg;
    assign clr_addr      = clr_cnt_reg;
    assign stat.clearing = clearing_reg;
    assign stat.reducing = reducing_reg;

endmodule

`default_nettype wire

@@ src/samr_mix.sv @@
// ----------------------------------------------------------------------------
// Saturating audio mix into ring - mix stage
// Takes the stored value from the ring read, forwards a write to the same
// entry made in the read cycle, forms the saturated or copied value, writes
// it back and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module samr_mix
    import samr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire fmt_t                  fmt,
    input  wire logic                  issue_valid,
    input  wire wr_req_t               issue_req,
    input  wire logic [SAMPLE_W-1:0]   rdata,
    input  wire logic                  out_ready,
    output logic                       adv,
    output logic                       ram_we,
    output logic [ADDR_W-1:0]          ram_waddr,
    output logic [SAMPLE_W-1:0]        ram_wdata,
    output logic                       out_valid,
    output logic [ADDR_OUT_W-1:0]      address,
    output logic [SAMPLE_W-1:0]        value,
    output logic                       was_mixed,
    output logic                       run_end
);

    logic                  m_valid_reg;
    wr_req_t               m_req_reg;
    logic                  fwd_hit_reg;
    logic [SAMPLE_W-1:0]   fwd_data_reg;
    logic                  out_valid_reg;
    logic [ADDR_OUT_W-1:0] address_reg;
    logic [SAMPLE_W-1:0]   value_reg;
    logic                  was_mixed_reg;
    logic                  run_end_reg;

    logic [SAMPLE_W-1:0]   stored;
    logic [SAMPLE_W-1:0]   result;
    logic                  fwd_hit_next;

    always_comb
    begin
        adv    = !out_valid_reg || out_ready;
        stored = fwd_hit_reg ? fwd_data_reg : rdata;
        if (m_req_reg.mixed)
            result = sat_mix(fmt, m_req_reg.sample, stored);
        else
            result = copy_val(fmt, m_req_reg.sample);
        // The RAM returns old data when the entry is written in the read cycle.
        fwd_hit_next = m_valid_reg && issue_valid && (issue_req.addr == m_req_reg.addr);
        ram_we    = adv && m_valid_reg;
        ram_waddr = m_req_reg.addr;
        ram_wdata = result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg   <= issue_valid;
            out_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_req_reg    <= issue_req;
            fwd_hit_reg  <= fwd_hit_next;
            fwd_data_reg <= result;
            if (m_valid_reg)
            begin
                address_reg   <= ADDR_OUT_W'(m_req_reg.addr);
                value_reg     <= result;
                was_mixed_reg <= m_req_reg.mixed;
                run_end_reg   <= m_req_reg.last;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign address   = address_reg;
    assign value     = value_reg;
    assign was_mixed = was_mixed_reg;
    assign run_end   = run_end_reg;

endmodule

`default_nettype wire

@@ src/saturating_audio_mix_into_ring_top.sv @@
// ----------------------------------------------------------------------------
// Saturating audio mix into ring - top level
// Mixes runs of source samples into a sink ring held in on-chip RAM.
// ----------------------------------------------------------------------------
// The block takes one sample transaction per cycle unless the output stalls
// or a clearing pass or index reduction runs, and returns one write report
// per sample, in order, through the pipelined modulo unit that wraps the run
// start into the ring, the address stage and ring read, and the saturating
// add, write-back and output register. The ring RAM is read and written once
// per sample, and a write to the entry being read is forwarded. After reset
// the block clears all 4096 ring entries, one entry per cycle, before it
// accepts samples; configuration writes are taken meanwhile. A ring size write
// holds off samples while the write index is reduced to the new size.
// Configuration is to be written only when no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module saturating_audio_mix_into_ring_top
    import samr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_W-1:0]    sample,
    input  wire logic                   first,
    input  wire logic [START_W-1:0]     sink_start,
    input  wire logic [OFFSET_W-1:0]    start_offset,
    input  wire logic [COUNT_W-1:0]     mixed_count,
    input  wire logic                   last,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [ADDR_OUT_W-1:0]       address,
    output logic [SAMPLE_W-1:0]         value,
    output logic                        was_mixed,
    output logic                        run_end,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    fmt_t              fmt_reg;
    logic [SIZE_W-1:0] size_reg;

    logic              cfg_wr;
    logic              reduce_start;
    logic              accept;
    item_t             load_item;
    logic [SUM_W-1:0]  load_sum;

    logic              adv;
    logic              d_valid;
    item_t             d_item;
    logic [ADDR_W-1:0] d_rem;
    logic              issue_valid;
    wr_req_t           issue_req;
    logic              clr_we;
    logic [ADDR_W-1:0] clr_addr;
    seq_stat_t         stat;

    logic                mix_we;
    logic [ADDR_W-1:0]   mix_waddr;
    logic [SAMPLE_W-1:0] mix_wdata;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic [SAMPLE_W-1:0] ram_rdata;

    assign cfg_ready    = !stat.reducing;
    assign cfg_wr       = cfg_valid && cfg_ready;
    assign reduce_start = cfg_wr && (cfg_index == REG_RING_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg  <= FMT_32;
            size_reg <= eff_size(RING_SIZE_RESET);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_FORMAT:    fmt_reg  <= cfg_data[FMT_W-1:0];
                REG_RING_SIZE: size_reg <= eff_size(RSIZE_W'(cfg_data));
                default:       ;
            endcase
        end
    end

    assign in_ready = adv && !stat.clearing && !stat.reducing;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        load_item.sample   = sample;
        load_item.first    = first;
        load_item.last     = last;
        load_item.mix_init = (mixed_count > start_offset) ? mixed_count - start_offset : '0;
        load_sum           = SUM_W'(sink_start) + SUM_W'(start_offset);
    end

    samr_modpipe u_modpipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .load      (accept),
        .load_item (load_item),
        .load_sum  (load_sum),
        .ring_size (size_reg),
        .d_valid   (d_valid),
        .d_item    (d_item),
        .d_rem     (d_rem)
    );

    samr_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .d_valid      (d_valid),
        .d_item       (d_item),
        .d_rem        (d_rem),
        .ring_size    (size_reg),
        .reduce_start (reduce_start),
        .issue_valid  (issue_valid),
        .issue_req    (issue_req),
        .clr_we       (clr_we),
        .clr_addr     (clr_addr),
        .stat         (stat)
    );

    // The clearing pass owns the write port until it finishes.
    assign ram_we    = clr_we || mix_we;
    assign ram_waddr = clr_we ? clr_addr : mix_waddr;
    assign ram_wdata = clr_we ? '0 : mix_wdata;

    samr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue_valid),
        .raddr (issue_req.addr),
        .rdata (ram_rdata)
    );

    samr_mix u_mix (
        .clk         (clk),
        .rst_n       (rst_n),
        .fmt         (fmt_reg),
        .issue_valid (issue_valid),
        .issue_req   (issue_req),
        .rdata       (ram_rdata),
        .out_ready   (out_ready),
        .adv         (adv),
        .ram_we      (mix_we),
        .ram_waddr   (mix_waddr),
        .ram_wdata   (mix_wdata),
        .out_valid   (out_valid),
        .address     (address),
        .value       (value),
        .was_mixed   (was_mixed),
        .run_end     (run_end)
    );

endmodule

`default_nettype wire

@@ src/samr_checker.sv @@
// ----------------------------------------------------------------------------
// Saturating audio mix into ring - port checker
// Watches the ports of the top level over time and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "saturating_audio_mix_into_ring_top_macros.svh"

module samr_checker
    import samr_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [ADDR_OUT_W-1:0]  address,
    input wire logic [SAMPLE_W-1:0]    value,
    input wire logic                   was_mixed,
    input wire logic                   run_end,
    input wire logic                   cfg_valid,
    input wire logic                   cfg_ready,
    input wire logic [CFG_INDEX_W-1:0] cfg_index
);

    // A stalled result transaction keeps its contents.
    `SAMR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(address) && $stable(value) && $stable(was_mixed) && $stable(run_end))

    // Samples are only taken when configuration writes are taken too.
    `SAMR_ASSERT_NOW(a_in_implies_cfg, in_ready, cfg_ready)

    // A ring size write starts the index reduction, which blocks both ports.
    `SAMR_ASSERT_NEXT(a_size_write_blocks, cfg_valid && cfg_ready && (cfg_index == REG_RING_SIZE), !in_ready && !cfg_ready)

endmodule

bind saturating_audio_mix_into_ring_top samr_checker u_samr_checker (.*);

`default_nettype wire
